### sv/anchor_detection_decoder_top_macros.svh
// Assertion helpers shared by the decoder RTL.
`ifndef ANCHOR_DETECTION_DECODER_TOP_MACROS_SVH
`define ANCHOR_DETECTION_DECODER_TOP_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ADEC_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("adec: same-cycle check failed");

// Next-cycle implication, held off during reset.
`define ADEC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("adec: next-cycle check failed");

`endif

### sv/adec_pkg.sv
package adec_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int RATIO_BITS = 24;
    localparam int RATIO_FRAC = 16;
    localparam int SIZE_BITS  = 14;
    localparam int THR_BITS   = 17;
    localparam int CLS_BITS   = 8;
    localparam int SEG_BITS   = 7;
    localparam int LABEL_BITS = 8;
    localparam int IDX_BITS   = 9;
    localparam int BOX_ATTRS  = 4;

    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;

    // attribute positions of the box at the head of an anchor
    localparam logic [IDX_BITS-1:0] ATTR_CX = 9'd0;
    localparam logic [IDX_BITS-1:0] ATTR_CY = 9'd1;
    localparam logic [IDX_BITS-1:0] ATTR_W  = 9'd2;
    localparam logic [IDX_BITS-1:0] ATTR_H  = 9'd3;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_COEFF  = 1'b1;

    localparam logic [THR_BITS-1:0]   RST_CONF_THRESHOLD = 17'd16384;
    localparam logic [CLS_BITS-1:0]   RST_NUM_CLASSES    = 8'd1;
    localparam logic [SEG_BITS-1:0]   RST_SEG_CHANNELS   = 7'd32;
    localparam logic [RATIO_BITS-1:0] RST_X_RATIO        = 24'd65536;
    localparam logic [RATIO_BITS-1:0] RST_Y_RATIO        = 24'd65536;
    localparam logic [SIZE_BITS-1:0]  RST_IMAGE_WIDTH    = 14'd640;
    localparam logic [SIZE_BITS-1:0]  RST_IMAGE_HEIGHT   = 14'd480;

    typedef enum logic [2:0] {
        REG_CONF_THRESHOLD = 3'd0,
        REG_NUM_CLASSES    = 3'd1,
        REG_SEG_CHANNELS   = 3'd2,
        REG_X_RATIO        = 3'd3,
        REG_Y_RATIO        = 3'd4,
        REG_IMAGE_WIDTH    = 3'd5,
        REG_IMAGE_HEIGHT   = 3'd6
    } t_reg_idx;

    // load enables of the two box pipeline stages
    typedef struct packed {
        logic s2;
        logic s3;
    } t_stage_en;

endpackage

### sv/adec_in_if.sv
interface adec_in_if #(
    parameter int VALUE_BITS = adec_pkg::VALUE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

### sv/adec_out_if.sv
interface adec_out_if #(
    parameter int VALUE_BITS = adec_pkg::VALUE_BITS_DEF
);
    logic                                 valid;
    logic                                 ready;
    logic                                 kind;
    logic [adec_pkg::LABEL_BITS-1:0]      label;
    logic signed [VALUE_BITS-1:0]         score;
    logic [adec_pkg::SIZE_BITS-1:0]       left;
    logic [adec_pkg::SIZE_BITS-1:0]       top;
    logic [adec_pkg::SIZE_BITS-1:0]       box_width;
    logic [adec_pkg::SIZE_BITS-1:0]       box_height;
    logic signed [VALUE_BITS-1:0]         coeff;
    logic                                 last;

    modport source (output valid, output kind, output label, output score, output left,
                    output top, output box_width, output box_height, output coeff,
                    output last, input ready);
    modport sink   (input valid, input kind, input label, input score, input left,
                    input top, input box_width, input box_height, input coeff,
                    input last, output ready);
endinterface

### sv/adec_box_scale.sv
// One axis of the box: scale both edges, clamp to the image, take near edge and extent.
module adec_box_scale #(
    parameter int VALUE_BITS = adec_pkg::VALUE_BITS_DEF,
    parameter int FRAC_BITS  = adec_pkg::FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  adec_pkg::t_stage_en                  i_en,
    input  logic signed [VALUE_BITS+1:0]         i_twice_near,
    input  logic signed [VALUE_BITS+1:0]         i_twice_far,
    input  logic [adec_pkg::RATIO_BITS-1:0]      i_ratio,
    input  logic [adec_pkg::SIZE_BITS-1:0]       i_size,
    output logic [adec_pkg::SIZE_BITS-1:0]       o_near,
    output logic [adec_pkg::SIZE_BITS-1:0]       o_extent
);

    localparam int MAG_BITS  = VALUE_BITS + 1;
    localparam int PROD_BITS = MAG_BITS + adec_pkg::RATIO_BITS;
    localparam int SHIFT     = adec_pkg::RATIO_FRAC + 1;
    localparam int Q_BITS    = PROD_BITS - SHIFT;
    localparam int EDGE_BITS = adec_pkg::SIZE_BITS + FRAC_BITS;
    localparam int CMP_BITS  = (Q_BITS > EDGE_BITS) ? Q_BITS : EDGE_BITS;

    logic [MAG_BITS-1:0]  mag_near, mag_far;
    logic [PROD_BITS-1:0] r_p_near, r_p_far;
    logic [Q_BITS-1:0]    q_near, q_far;
    logic [EDGE_BITS-1:0] lim;
    logic [EDGE_BITS-1:0] n_e_near, n_e_far;
    logic [EDGE_BITS-1:0] r_e_near, r_e_far;
    logic [EDGE_BITS-1:0] diff;

    // negative or zero sums scale to zero
    assign mag_near = i_twice_near[VALUE_BITS+1] ? '0 : i_twice_near[MAG_BITS-1:0];
    assign mag_far  = i_twice_far[VALUE_BITS+1]  ? '0 : i_twice_far[MAG_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_p_near <= PROD_BITS'(mag_near) * PROD_BITS'(i_ratio);
            r_p_far  <= PROD_BITS'(mag_far) * PROD_BITS'(i_ratio);
        end
    end

    assign q_near = r_p_near[PROD_BITS-1:SHIFT];
    assign q_far  = r_p_far[PROD_BITS-1:SHIFT];
    assign lim    = {i_size, {FRAC_BITS{1'b0}}};

    always_comb begin
        n_e_near = (CMP_BITS'(q_near) > CMP_BITS'(lim)) ? lim : EDGE_BITS'(q_near);
        n_e_far  = (CMP_BITS'(q_far) > CMP_BITS'(lim))  ? lim : EDGE_BITS'(q_far);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_e_near <= n_e_near;
            r_e_far  <= n_e_far;
        end
    end

    assign diff     = r_e_far - r_e_near;
    assign o_near   = r_e_near[EDGE_BITS-1:FRAC_BITS];
    assign o_extent = (r_e_far >= r_e_near) ? diff[EDGE_BITS-1:FRAC_BITS] : '0;

endmodule

### sv/anchor_detection_decoder_top.sv
// Channel  | Direction | Beat contents
// i_in     | in        | value: one anchor attribute, signed fixed point
// o_out    | out       | kind, label, score, left, top, box_width, box_height, coeff, last
// APB      | in/out    | register writes and reads, pready always high
//
// One attribute beat is taken per cycle while i_in.ready is high; each result is registered at every stage below.
// The depth is set by the box path: accept stage, ratio multiply, clamp, result register.
// Synchronous active-low reset restores the anchor state and registers to reset values and clears pipeline valids.
// Up to four results wait in the pipeline when o_out stalls; i_in.ready drops only then.
`include "anchor_detection_decoder_top_macros.svh"

module anchor_detection_decoder_top #(
    parameter int VALUE_BITS = adec_pkg::VALUE_BITS_DEF,
    parameter int FRAC_BITS  = adec_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    adec_in_if.sink                               i_in,
    adec_out_if.source                            o_out,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [adec_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [adec_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [adec_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                  pready
);

    localparam int IB  = adec_pkg::IDX_BITS;
    localparam int LB  = adec_pkg::LABEL_BITS;
    localparam int SB  = adec_pkg::SIZE_BITS;
    localparam int DB  = adec_pkg::APB_DATA_BITS;
    localparam int TW  = VALUE_BITS + 2;
    localparam int TCW = VALUE_BITS + adec_pkg::THR_BITS + 1;
    localparam logic signed [VALUE_BITS-1:0] MOST_NEG = {1'b1, {(VALUE_BITS-1){1'b0}}};

    // configuration registers
    logic [adec_pkg::THR_BITS-1:0]   r_conf_threshold;
    logic [adec_pkg::CLS_BITS-1:0]   r_num_classes;
    logic [adec_pkg::SEG_BITS-1:0]   r_seg_channels;
    logic [adec_pkg::RATIO_BITS-1:0] r_x_ratio, r_y_ratio;
    logic [SB-1:0]                   r_image_width, r_image_height;
    adec_pkg::t_reg_idx              reg_idx;
    logic                            cfg_wr;

    assign reg_idx = adec_pkg::t_reg_idx'(paddr[adec_pkg::APB_ADDR_BITS-1:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conf_threshold <= adec_pkg::RST_CONF_THRESHOLD;
            r_num_classes    <= adec_pkg::RST_NUM_CLASSES;
            r_seg_channels   <= adec_pkg::RST_SEG_CHANNELS;
            r_x_ratio        <= adec_pkg::RST_X_RATIO;
            r_y_ratio        <= adec_pkg::RST_Y_RATIO;
            r_image_width    <= adec_pkg::RST_IMAGE_WIDTH;
            r_image_height   <= adec_pkg::RST_IMAGE_HEIGHT;
        end else if (cfg_wr) begin
            case (reg_idx)
                adec_pkg::REG_CONF_THRESHOLD: r_conf_threshold <= pwdata[adec_pkg::THR_BITS-1:0];
                adec_pkg::REG_NUM_CLASSES:    r_num_classes    <= pwdata[adec_pkg::CLS_BITS-1:0];
                adec_pkg::REG_SEG_CHANNELS:   r_seg_channels   <= pwdata[adec_pkg::SEG_BITS-1:0];
                adec_pkg::REG_X_RATIO:        r_x_ratio        <= pwdata[adec_pkg::RATIO_BITS-1:0];
                adec_pkg::REG_Y_RATIO:        r_y_ratio        <= pwdata[adec_pkg::RATIO_BITS-1:0];
                adec_pkg::REG_IMAGE_WIDTH:    r_image_width    <= pwdata[SB-1:0];
                adec_pkg::REG_IMAGE_HEIGHT:   r_image_height   <= pwdata[SB-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            adec_pkg::REG_CONF_THRESHOLD: prdata = DB'(r_conf_threshold);
            adec_pkg::REG_NUM_CLASSES:    prdata = DB'(r_num_classes);
            adec_pkg::REG_SEG_CHANNELS:   prdata = DB'(r_seg_channels);
            adec_pkg::REG_X_RATIO:        prdata = DB'(r_x_ratio);
            adec_pkg::REG_Y_RATIO:        prdata = DB'(r_y_ratio);
            adec_pkg::REG_IMAGE_WIDTH:    prdata = DB'(r_image_width);
            adec_pkg::REG_IMAGE_HEIGHT:   prdata = DB'(r_image_height);
            default:                      prdata = '0;
        endcase
    end

    // pipeline flow: each stage advances when its successor is empty or advancing
    logic r_v1, r_v2, r_v3, r_vo;
    logic en1, en2, en3, en_o;
    logic accept;
    adec_pkg::t_stage_en box_en;

    assign en_o       = !r_vo || o_out.ready;
    assign en3        = !r_v3 || en_o;
    assign en2        = !r_v2 || en3;
    assign en1        = !r_v1 || en2;
    assign i_in.ready = en1;
    assign accept     = i_in.valid && en1;
    assign box_en.s2  = en2;
    assign box_en.s3  = en3;

    // anchor state
    logic [IB-1:0]                r_attr_idx;
    logic signed [VALUE_BITS-1:0] r_best_score;
    logic [LB-1:0]                r_best_label;
    logic signed [VALUE_BITS-1:0] r_center_x, r_center_y, r_size_w, r_size_h;
    logic                         r_kept;

    logic signed [VALUE_BITS-1:0] v;
    logic [adec_pkg::CLS_BITS-1:0] nc;
    logic [IB-1:0]                score_end, total;
    logic                         is_last, in_box, in_score, last_score, better;
    logic signed [VALUE_BITS-1:0] best_nx;
    logic [LB-1:0]                label_nx;
    logic                         thr_pass, emit_hdr, emit_coef;

    always_comb begin
        v          = i_in.value;
        nc         = (r_num_classes == '0) ? adec_pkg::CLS_BITS'(1) : r_num_classes;
        score_end  = IB'(adec_pkg::BOX_ATTRS) + IB'(nc);
        total      = score_end + IB'(r_seg_channels);
        is_last    = ((IB+1)'(r_attr_idx) + (IB+1)'(1)) >= (IB+1)'(total);
        in_box     = r_attr_idx < IB'(adec_pkg::BOX_ATTRS);
        in_score   = !in_box && (r_attr_idx < score_end);
        last_score = r_attr_idx == (score_end - IB'(1));
        better     = in_score && (v > r_best_score);
        best_nx    = better ? v : r_best_score;
        label_nx   = better ? LB'(r_attr_idx - IB'(adec_pkg::BOX_ATTRS)) : r_best_label;
        thr_pass   = TCW'(best_nx) > TCW'($signed({1'b0, r_conf_threshold}));
        emit_hdr   = in_score && last_score && thr_pass;
        emit_coef  = !in_box && !in_score && r_kept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr_idx   <= '0;
            r_best_score <= MOST_NEG;
            r_best_label <= '0;
            r_kept       <= 1'b0;
            r_center_x   <= '0;
            r_center_y   <= '0;
            r_size_w     <= '0;
            r_size_h     <= '0;
        end else if (accept) begin
            if (r_attr_idx == adec_pkg::ATTR_CX) r_center_x <= v;
            if (r_attr_idx == adec_pkg::ATTR_CY) r_center_y <= v;
            if (r_attr_idx == adec_pkg::ATTR_W)  r_size_w   <= v;
            if (r_attr_idx == adec_pkg::ATTR_H)  r_size_h   <= v;
            if (in_score) begin
                r_best_score <= best_nx;
                r_best_label <= label_nx;
            end
            if (emit_hdr) r_kept <= 1'b1;
            // end of anchor: clear for the next one
            if (is_last) begin
                r_attr_idx   <= '0;
                r_best_score <= MOST_NEG;
                r_best_label <= '0;
                r_kept       <= 1'b0;
            end else begin
                r_attr_idx   <= r_attr_idx + IB'(1);
            end
        end
    end

    // stage 1: result fields and doubled edge sums
    logic                         r1_kind, r1_last;
    logic [LB-1:0]                r1_label;
    logic signed [VALUE_BITS-1:0] r1_score, r1_coeff;
    logic signed [TW-1:0]         r1_tx_near, r1_tx_far, r1_ty_near, r1_ty_far;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= accept && (emit_hdr || emit_coef);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_kind    <= emit_hdr ? adec_pkg::KIND_HEADER : adec_pkg::KIND_COEFF;
            r1_last    <= is_last;
            r1_label   <= emit_hdr ? label_nx : '0;
            r1_score   <= emit_hdr ? best_nx : '0;
            r1_coeff   <= emit_coef ? v : '0;
            r1_tx_near <= TW'(r_center_x) + TW'(r_center_x) - TW'(r_size_w);
            r1_tx_far  <= TW'(r_center_x) + TW'(r_center_x) + TW'(r_size_w);
            r1_ty_near <= TW'(r_center_y) + TW'(r_center_y) - TW'(r_size_h);
            r1_ty_far  <= TW'(r_center_y) + TW'(r_center_y) + TW'(r_size_h);
        end
    end

    // stages 2 and 3: result fields travel beside the box pipeline
    logic                         r2_kind, r2_last, r3_kind, r3_last;
    logic [LB-1:0]                r2_label, r3_label;
    logic signed [VALUE_BITS-1:0] r2_score, r2_coeff, r3_score, r3_coeff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_kind  <= r1_kind;
            r2_last  <= r1_last;
            r2_label <= r1_label;
            r2_score <= r1_score;
            r2_coeff <= r1_coeff;
        end
        if (en3) begin
            r3_kind  <= r2_kind;
            r3_last  <= r2_last;
            r3_label <= r2_label;
            r3_score <= r2_score;
            r3_coeff <= r2_coeff;
        end
    end

    logic [SB-1:0] x_near, x_extent, y_near, y_extent;

    adec_box_scale #(
        .VALUE_BITS (VALUE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_box_x (
        .i_clk        (i_clk),
        .i_en         (box_en),
        .i_twice_near (r1_tx_near),
        .i_twice_far  (r1_tx_far),
        .i_ratio      (r_x_ratio),
        .i_size       (r_image_width),
        .o_near       (x_near),
        .o_extent     (x_extent)
    );

    adec_box_scale #(
        .VALUE_BITS (VALUE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_box_y (
        .i_clk        (i_clk),
        .i_en         (box_en),
        .i_twice_near (r1_ty_near),
        .i_twice_far  (r1_ty_far),
        .i_ratio      (r_y_ratio),
        .i_size       (r_image_height),
        .o_near       (y_near),
        .o_extent     (y_extent)
    );

    // result register
    logic                         r_o_kind, r_o_last;
    logic [LB-1:0]                r_o_label;
    logic signed [VALUE_BITS-1:0] r_o_score, r_o_coeff;
    logic [SB-1:0]                r_o_left, r_o_top, r_o_box_width, r_o_box_height;
    logic                         hdr3;

    assign hdr3 = r3_kind == adec_pkg::KIND_HEADER;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (en_o) begin
            r_vo <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_o_kind       <= r3_kind;
            r_o_last       <= r3_last;
            r_o_label      <= r3_label;
            r_o_score      <= r3_score;
            r_o_coeff      <= r3_coeff;
            // coefficient beats carry no box
            r_o_left       <= hdr3 ? x_near : '0;
            r_o_top        <= hdr3 ? y_near : '0;
            r_o_box_width  <= hdr3 ? x_extent : '0;
            r_o_box_height <= hdr3 ? y_extent : '0;
        end
    end

    assign o_out.valid      = r_vo;
    assign o_out.kind       = r_o_kind;
    assign o_out.label      = r_o_label;
    assign o_out.score      = r_o_score;
    assign o_out.left       = r_o_left;
    assign o_out.top        = r_o_top;
    assign o_out.box_width  = r_o_box_width;
    assign o_out.box_height = r_o_box_height;
    assign o_out.coeff      = r_o_coeff;
    assign o_out.last       = r_o_last;

    `ADEC_ASSERT_IMPL(a_hdr_no_coeff, i_clk, i_rst_n, r_vo && r_o_kind == adec_pkg::KIND_HEADER, r_o_coeff == '0)
    `ADEC_ASSERT_IMPL(a_coeff_no_box, i_clk, i_rst_n, r_vo && r_o_kind == adec_pkg::KIND_COEFF, r_o_label == '0 && r_o_score == '0 && r_o_left == '0 && r_o_top == '0 && r_o_box_width == '0 && r_o_box_height == '0)
    `ADEC_ASSERT_NEXT(a_stall_keeps_result, i_clk, i_rst_n, r_vo && !o_out.ready, r_vo)
    `ADEC_ASSERT_NEXT(a_anchor_clears, i_clk, i_rst_n, accept && is_last, r_attr_idx == '0 && r_best_label == '0 && !r_kept)

endmodule

### verif/tb.sv
module tb;
    import adec_pkg::*;

    localparam int VB          = VALUE_BITS_DEF;
    localparam int FB          = FRAC_BITS_DEF;
    localparam int RANDOM_BEATS = 1420;
    localparam int PIPE_DRAIN  = 8;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic                    kind;
        logic [LABEL_BITS-1:0]   label;
        logic signed [VB-1:0]    score;
        logic [SIZE_BITS-1:0]    left;
        logic [SIZE_BITS-1:0]    top;
        logic [SIZE_BITS-1:0]    box_width;
        logic [SIZE_BITS-1:0]    box_height;
        logic signed [VB-1:0]    coeff;
        logic                    last;
    } det_t;

    class detection_scoreboard;
        logic [THR_BITS-1:0]   thr;
        logic [CLS_BITS-1:0]   n_cls;
        logic [SEG_BITS-1:0]   n_seg;
        logic [RATIO_BITS-1:0] xr;
        logic [RATIO_BITS-1:0] yr;
        logic [SIZE_BITS-1:0]  img_w;
        logic [SIZE_BITS-1:0]  img_h;

        logic [IDX_BITS-1:0]   idx;
        longint                best;
        logic [LABEL_BITS-1:0] best_lbl;
        longint                cx, cy, sw, sh;
        bit                    kept;

        det_t due_results[$];
        int   errors;
        int   n_beats;
        int   n_headers;
        int   n_coeffs;

        function new();
            thr   = RST_CONF_THRESHOLD;
            n_cls = RST_NUM_CLASSES;
            n_seg = RST_SEG_CHANNELS;
            xr    = RST_X_RATIO;
            yr    = RST_Y_RATIO;
            img_w = RST_IMAGE_WIDTH;
            img_h = RST_IMAGE_HEIGHT;
            cx = 0;
            cy = 0;
            sw = 0;
            sh = 0;
            errors    = 0;
            n_beats   = 0;
            n_headers = 0;
            n_coeffs  = 0;
            clear_anchor();
        endfunction

        function void clear_anchor();
            idx      = '0;
            best     = -(longint'(1) << (VB - 1));
            best_lbl = '0;
            kept     = 1'b0;
        endfunction

        function int class_count();
            return (n_cls == 0) ? 1 : int'(n_cls);
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // append one expected result behind those already waiting
        function void add_due(det_t r);
            due_results.insert(due_results.size(), r);
        endfunction

        function void write_reg(t_reg_idx r, logic [31:0] d);
            case (r)
                REG_CONF_THRESHOLD: thr   = d[THR_BITS-1:0];
                REG_NUM_CLASSES:    n_cls = d[CLS_BITS-1:0];
                REG_SEG_CHANNELS:   n_seg = d[SEG_BITS-1:0];
                REG_X_RATIO:        xr    = d[RATIO_BITS-1:0];
                REG_Y_RATIO:        yr    = d[RATIO_BITS-1:0];
                REG_IMAGE_WIDTH:    img_w = d[SIZE_BITS-1:0];
                REG_IMAGE_HEIGHT:   img_h = d[SIZE_BITS-1:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(t_reg_idx r);
            case (r)
                REG_CONF_THRESHOLD: return 32'(thr);
                REG_NUM_CLASSES:    return 32'(n_cls);
                REG_SEG_CHANNELS:   return 32'(n_seg);
                REG_X_RATIO:        return 32'(xr);
                REG_Y_RATIO:        return 32'(yr);
                REG_IMAGE_WIDTH:    return 32'(img_w);
                REG_IMAGE_HEIGHT:   return 32'(img_h);
                default:            return 32'd0;
            endcase
        endfunction

        // centre -/+ half size, scaled by a Q8.16 ratio and clamped to the image
        function longint unsigned scaled_edge(longint twice, logic [RATIO_BITS-1:0] ratio,
                                              logic [SIZE_BITS-1:0] size);
            longint unsigned prod;
            longint unsigned lim;
            lim = longint'(size) << FB;
            if (twice <= 0 || ratio == 0)
                return 0;
            prod = longint'(twice) * longint'(ratio);
            prod = prod >> (RATIO_FRAC + 1);
            return (prod > lim) ? lim : prod;
        endfunction

        function void note_value(logic signed [VB-1:0] value);
            longint          v;
            longint unsigned x0, x1, y0, y1;
            int              nc;
            int              total;
            bit              at_end;
            det_t            r;
            v      = value;
            nc     = class_count();
            total  = BOX_ATTRS + nc + int'(n_seg);
            at_end = (int'(idx) + 1 >= total);
            n_beats++;
            if (idx < BOX_ATTRS) begin
                case (idx)
                    ATTR_CX: cx = v;
                    ATTR_CY: cy = v;
                    ATTR_W:  sw = v;
                    default: sh = v;
                endcase
            end else if (int'(idx) < BOX_ATTRS + nc) begin
                if (v > best) begin
                    best     = v;
                    best_lbl = LABEL_BITS'(int'(idx) - BOX_ATTRS);
                end
                if (int'(idx) == BOX_ATTRS - 1 + nc && best > longint'(thr)) begin
                    x0 = scaled_edge(2 * cx - sw, xr, img_w);
                    x1 = scaled_edge(2 * cx + sw, xr, img_w);
                    y0 = scaled_edge(2 * cy - sh, yr, img_h);
                    y1 = scaled_edge(2 * cy + sh, yr, img_h);
                    kept         = 1'b1;
                    r            = '0;
                    r.kind       = KIND_HEADER;
                    r.label      = best_lbl;
                    r.score      = VB'(best);
                    r.left       = SIZE_BITS'(x0 >> FB);
                    r.top        = SIZE_BITS'(y0 >> FB);
                    r.box_width  = (x1 >= x0) ? SIZE_BITS'((x1 - x0) >> FB) : '0;
                    r.box_height = (y1 >= y0) ? SIZE_BITS'((y1 - y0) >> FB) : '0;
                    r.last       = at_end;
                    add_due(r);
                end
            end else if (kept) begin
                r       = '0;
                r.kind  = KIND_COEFF;
                r.coeff = value;
                r.last  = at_end;
                add_due(r);
            end
            if (at_end)
                clear_anchor();
            else
                idx = idx + 1'b1;
        endfunction

        function void match_field(string field, logic signed [63:0] want, logic signed [63:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(det_t got);
            det_t want;
            if (due_results.size() == 0) begin
                $error("result with nothing expected: kind %0d coeff %0d", got.kind, got.coeff);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (want.kind == KIND_HEADER)
                n_headers++;
            else
                n_coeffs++;
            match_field("kind",       64'(want.kind),       64'(got.kind));
            match_field("label",      64'(want.label),      64'(got.label));
            match_field("score",      want.score,           got.score);
            match_field("left",       64'(want.left),       64'(got.left));
            match_field("top",        64'(want.top),        64'(got.top));
            match_field("box_width",  64'(want.box_width),  64'(got.box_width));
            match_field("box_height", 64'(want.box_height), 64'(got.box_height));
            match_field("coeff",      want.coeff,           got.coeff);
            match_field("last",       64'(want.last),       64'(got.last));
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    adec_in_if  in_bus ();
    adec_out_if out_bus ();

    anchor_detection_decoder_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    detection_scoreboard sb;
    det_t seen;
    int   src_idle;
    int   snk_idle;
    int   beats_sent;
    int   reg_writes;
    int   stall_cnt;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        out_bus.ready = ($urandom_range(0, 99) >= snk_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_bus.valid && in_bus.ready)
                sb.note_value(in_bus.value);
            if (out_bus.valid && out_bus.ready) begin
                seen.kind       = out_bus.kind;
                seen.label      = out_bus.label;
                seen.score      = out_bus.score;
                seen.left       = out_bus.left;
                seen.top        = out_bus.top;
                seen.box_width  = out_bus.box_width;
                seen.box_height = out_bus.box_height;
                seen.coeff      = out_bus.coeff;
                seen.last       = out_bus.last;
                sb.check_result(seen);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
                (psel && penable && pready))
                stall_cnt = 0;
            else
                stall_cnt++;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // call at a falling edge; returns at the falling edge after the beat
    task automatic send_value(input logic [VB-1:0] v);
        while ($urandom_range(0, 99) < src_idle) begin
            in_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        in_bus.valid = 1'b1;
        in_bus.value = v;
        @(posedge i_clk);
        while (!in_bus.ready)
            @(posedge i_clk);
        @(negedge i_clk);
        beats_sent++;
    endtask

    // hold the sender until every result is out and the pipeline is empty
    task automatic settle();
        in_bus.valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (PIPE_DRAIN) @(negedge i_clk);
    endtask

    task automatic apb_write(input t_reg_idx r, input logic [31:0] d);
        logic [31:0] rd;
        paddr   = {r, 2'b00};
        pwdata  = d;
        pwrite  = 1'b1;
        psel    = 1'b1;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        sb.write_reg(r, d);
        reg_writes++;
        @(negedge i_clk);
        // read back straight after, psel held
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        rd = prdata;
        if (rd !== sb.reg_value(r)) begin
            $error("prdata: expected %0d, got %0d", sb.reg_value(r), rd);
            sb.errors++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    function automatic logic [31:0] reg_pick(t_reg_idx r);
        logic [31:0] d;
        int          c;
        c = $urandom_range(0, 9);
        case (r)
            REG_CONF_THRESHOLD:
                d = (c == 0) ? 32'd0 : (c == 1) ? 32'd131071 : (c == 2) ? 32'd65536 :
                    (c < 6) ? 32'd16384 : $urandom_range(0, 131071);
            REG_NUM_CLASSES:
                d = (c == 0) ? 32'd0 : (c == 1) ? 32'd255 :
                    (c == 2) ? $urandom_range(7, 40) : $urandom_range(1, 6);
            REG_SEG_CHANNELS:
                d = (c == 0) ? 32'd0 : (c == 1) ? 32'd127 : (c == 2) ? 32'd64 :
                    $urandom_range(0, 6);
            REG_X_RATIO, REG_Y_RATIO:
                d = (c == 0) ? 32'd0 : (c == 1) ? 32'hFF_FFFF :
                    (c == 2) ? $urandom_range(0, 32'hFF_FFFF) : $urandom_range(16384, 196608);
            default:
                d = (c == 0) ? 32'd0 : (c == 1) ? 32'd16383 : (c == 2) ? 32'd8192 :
                    (c == 3) ? 32'd1 : $urandom_range(64, 2000);
        endcase
        // stray upper bits must be dropped by the register
        if ($urandom_range(0, 3) == 0)
            d[31:24] = 8'($urandom_range(1, 255));
        return d;
    endfunction

    task automatic random_config(input bit all_regs);
        for (int k = 0; k <= int'(REG_IMAGE_HEIGHT); k++) begin
            if (all_regs || $urandom_range(0, 9) < 6)
                apb_write(t_reg_idx'(k), reg_pick(t_reg_idx'(k)));
        end
    endtask

    // shape each beat by where the anchor currently stands
    function automatic logic [VB-1:0] pick_value();
        int pos;
        int nc;
        int c;
        pos = int'(sb.idx);
        nc  = sb.class_count();
        c   = $urandom_range(0, 19);
        if (c == 0)
            return $urandom();
        if (pos < BOX_ATTRS) begin
            if (c == 1)
                return $urandom();
            if (pos < 2)
                return {16'($urandom_range(0, 1400)), 16'($urandom())};
            return {16'($urandom_range(0, 800)), 16'($urandom())};
        end
        if (pos < BOX_ATTRS + nc) begin
            if (c == 1)
                return 32'h8000_0000;
            if (c == 2)
                return VB'(sb.best);
            if (c == 3)
                return 32'h7FFF_FFFF;
            return VB'(longint'(sb.thr) - 40000 + longint'($urandom_range(0, 80000)));
        end
        return $urandom();
    endfunction

    task automatic directed_part();
        apb_write(REG_NUM_CLASSES, 32'd3);
        apb_write(REG_SEG_CHANNELS, 32'd1);
        // plain box; tied top scores, first one wins
        send_value(32'h0064_0000);
        send_value(32'h0032_0000);
        send_value(32'h0028_8000);
        send_value(32'h0014_0000);
        send_value(32'h0000_8000);
        send_value(32'h7FFF_FFFF);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        // huge x saturates, negative height collapses the box
        send_value(32'h7FFF_FFFF);
        send_value(32'h000A_0000);
        send_value(32'h7FFF_FFFF);
        send_value(32'hFFEC_0000);
        send_value(32'h8000_0000);
        send_value(32'h8000_0000);
        send_value(32'h0001_0000);
        send_value(32'h7FFF_FFFF);
        // cut the anchor short after the first score
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        send_value(32'h0000_0000);
        send_value(32'hFFFF_FFFF);
        send_value(32'h7FFF_FFFF);
        settle();
        apb_write(REG_NUM_CLASSES, 32'd0);
        apb_write(REG_SEG_CHANNELS, 32'd0);
        apb_write(REG_CONF_THRESHOLD, 32'd0);
        apb_write(REG_X_RATIO, 32'hFF_FFFF);
        apb_write(REG_Y_RATIO, 32'd0);
        apb_write(REG_IMAGE_WIDTH, 32'd0);
        apb_write(REG_IMAGE_HEIGHT, 32'd16383);
        send_value(32'h1234_5678);
        // zero classes act as one, empty image gives an empty box
        send_value(32'h0010_0000);
        send_value(32'h0010_0000);
        send_value(32'h0008_0000);
        send_value(32'h0008_0000);
        send_value(32'h0000_0001);
        settle();
    endtask

    initial begin
        int cfg_gap;
        int since_cfg;
        sb            = new();
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_bus.valid  = 1'b0;
        in_bus.value  = '0;
        out_bus.ready = 1'b0;
        src_idle      = 20;
        snk_idle      = 87;
        beats_sent    = 0;
        reg_writes    = 0;
        stall_cnt     = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        directed_part();

        random_config(1'b1);
        cfg_gap   = $urandom_range(20, 120);
        since_cfg = 0;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n < RANDOM_BEATS / 3) begin
                src_idle = 20;
                snk_idle = 87;
            end else if (n < 2 * RANDOM_BEATS / 3) begin
                src_idle = 87;
                snk_idle = 20;
            end else begin
                src_idle = 0;
                snk_idle = 0;
            end
            if (since_cfg >= cfg_gap) begin
                settle();
                random_config(1'b0);
                cfg_gap   = $urandom_range(20, 120);
                since_cfg = 0;
            end
            send_value(pick_value());
            since_cfg++;
        end
        settle();

        $display("Sent %0d attribute beats across %0d register writes and three idle mixes.",
                 sb.n_beats, reg_writes);
        $display("Checked %0d detection headers and %0d mask coefficients.",
                 sb.n_headers, sb.n_coeffs);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
